>>> hdl/aps_pkg.sv
// Package for the automaton pattern search block.
// Holds the payload and control structs, register codes and sizing constants.
// No dependencies.
package aps_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int PAT_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 4;
	localparam int IDX_W       = 16;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 1;

	localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES  = 1'b0,
		REG_PATTERN_LENGTH = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              last_of_text;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] match_start;
	} out_item_t;

	// Shared control for the row of matcher cells.
	typedef struct packed {
		logic step;
		logic clear;
	} cell_ctl_t;

endpackage

>>> hdl/aps_cell.sv
// One matcher cell: tracks whether pattern prefix k+1 ends at the current byte.
// Depends on aps_pkg.
module aps_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  aps_pkg::cell_ctl_t         ctl,
	input  logic [aps_pkg::BYTE_W-1:0] text_byte,
	input  logic [aps_pkg::BYTE_W-1:0] pat_byte,
	input  logic                       prev_hit,
	output logic                       hit,
	output logic                       hit_next
);
	import aps_pkg::*;

	logic hit_q;

	// Extend the neighbour's partial match by one byte.
	assign hit_next = prev_hit && (text_byte == pat_byte);
	assign hit      = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q <= 1'b0;
		end else if (ctl.step) begin
			hit_q <= hit_next;
		end
	end

endmodule

>>> hdl/aps_out_buf.sv
// Two-entry output stage (output register plus skid register) for result requests.
// Depends on aps_pkg.
module aps_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  aps_pkg::out_item_t push_data,
	output logic              space,
	output logic              result_valid,
	input  logic              result_ready,
	output aps_pkg::out_item_t result
);
	import aps_pkg::*;

	logic      out_valid_q;
	logic      skid_valid_q;
	out_item_t out_q;
	out_item_t skid_q;
	logic      pop;

	assign pop          = out_valid_q && result_ready;
	assign space        = !skid_valid_q;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
		if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !result_ready) |=> (skid_valid_q && $stable(skid_q)))
		else $error("skid entry lost while output stalled");

endmodule

>>> hdl/automaton_pattern_search.sv
// A text request's result enters the output stage when the request is accepted.
// Throughput: one byte per cycle unless stalled; the row stops stepping after a match.
// A two-entry output stage keeps text flowing; text stalls only while both entries wait.
// Reset (arst_n low) clears match cells, byte index, report flag and output stage;
// pattern_bytes resets to 0 and pattern_length to 1. No clearing pass is needed.
module automaton_pattern_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          text_valid,
	output logic                          text_ready,
	input  aps_pkg::in_item_t             text,
	output logic                          result_valid,
	input  logic                          result_ready,
	output aps_pkg::out_item_t            result,
	input  logic                          cfg_we,
	input  logic [aps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aps_pkg::CFG_W-1:0]     cfg_data
);
	import aps_pkg::*;

	// Configuration registers.
	logic [CFG_W-1:0] pattern_q;
	logic [LEN_W-1:0] length_q;

	// Stream state: index of the next byte and the "result already given" flag.
	// The match state itself lives as one bit per cell in the row below
	// (bit k set means the first k+1 pattern bytes end at the latest byte).
	logic [IDX_W-1:0] byte_idx_q;
	logic             reported_q;

	logic                 text_accept;
	logic                 buf_space;
	logic [PAT_IDX_W-1:0] m_idx;
	cell_ctl_t            ctl;
	logic [MAX_PATTERN-1:0] hit;
	logic [MAX_PATTERN-1:0] hit_next;
	logic [MAX_PATTERN-1:0] prev_hit;
	logic                 found_now;
	logic                 push;
	out_item_t            push_data;

	// Accept text whenever the skid slot is free; the output register may be busy.
	assign text_ready  = buf_space;
	assign text_accept = text_valid && text_ready;

	// Effective pattern length minus one: treat 0 as 1, clamp above the cell count.
	always_comb begin
		if (length_q == '0) begin
			m_idx = '0;
		end else if (length_q > LEN_W'(MAX_PATTERN)) begin
			m_idx = PAT_IDX_W'(MAX_PATTERN - 1);
		end else begin
			m_idx = PAT_IDX_W'(length_q - LEN_W'(1));
		end
	end

	// Step the row only while still searching; drop the whole stream state at
	// the end of a text or on any register write so a text in progress restarts.
	assign ctl.step  = text_accept && !reported_q;
	assign ctl.clear = cfg_we || (text_accept && text.last_of_text);

	// Row of matcher cells: each cell takes its left neighbour's hit from the
	// previous byte, cell 0 always starts a fresh candidate.
	genvar k;
	generate
		for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
			if (k == 0) begin : g_head
				assign prev_hit[k] = 1'b1;
			end else begin : g_body
				assign prev_hit[k] = hit[k-1];
			end
			aps_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.text_byte (text.text_byte),
				.pat_byte  (pattern_q[k*BYTE_W +: BYTE_W]),
				.prev_hit  (prev_hit[k]),
				.hit       (hit[k]),
				.hit_next  (hit_next[k])
			);
		end
	endgenerate

	// A full match shows in the cell for the last pattern byte.
	assign found_now = ctl.step && hit_next[m_idx];

	// Report the first match, or "not found" at the last byte of a text without one.
	assign push = ctl.step && (found_now || text.last_of_text);

	always_comb begin
		push_data.found       = found_now;
		push_data.match_start = '0;
		if (found_now) begin
			// start = index + 1 - length, modulo the index width
			push_data.match_start = byte_idx_q - IDX_W'(m_idx);
		end
	end

	aps_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_data    (push_data),
		.space        (buf_space),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Configuration writes; each valid write also restarts the stream (see ctl.clear).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_BYTES:  pattern_q <= cfg_data;
				REG_PATTERN_LENGTH: length_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Byte index and report flag. The index keeps counting after a report until the
	// last byte of the text clears it; it holds at its maximum instead of wrapping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			reported_q <= 1'b0;
		end else if (ctl.clear) begin
			byte_idx_q <= '0;
			reported_q <= 1'b0;
		end else if (text_accept) begin
			if (byte_idx_q != IDX_MAX) begin
				byte_idx_q <= byte_idx_q + IDX_W'(1);
			end
			if (found_now) begin
				reported_q <= 1'b1;
			end
		end
	end

	a_match_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(found_now && !text.last_of_text && !cfg_we) |=> reported_q)
		else $error("match reported but search not stopped");

	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (byte_idx_q == '0 && !reported_q && hit == '0))
		else $error("register write did not restart the stream");

	a_index_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_idx_q == IDX_MAX && text_accept && !text.last_of_text && !cfg_we)
		|=> byte_idx_q == IDX_MAX)
		else $error("byte index wrapped");

	a_no_push_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		reported_q |-> !push)
		else $error("second result for one text");

endmodule

>>> verif/tb.sv
// Self-checking testbench for automaton_pattern_search.
// Predicts every search report from its own prefix automaton and scoreboards the result channel.
// Depends on aps_pkg and the automaton_pattern_search RTL only.
`timescale 1ns / 100ps

module tb;
	import aps_pkg::*;

	// Cycles to let pass after the last expected report before touching the registers:
	// a byte that gives no report may still be in flight.
	localparam int DRAIN_CYCLES = 4;
	// Quiet cycles tolerated before the run is declared hung. The longest legal quiet
	// stretch is the receiver hold-off below plus a few idle gaps.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int RANDOM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 40;
	localparam logic [IDX_W-1:0] INDEX_CEILING = IDX_MAX;

	logic clk = 1'b0;
	logic arst_n;

	logic                 text_valid;
	logic                 text_ready;
	in_item_t             text;
	logic                 result_valid;
	logic                 result_ready;
	out_item_t            result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Shadow of the block: configuration and stream state.
	logic [CFG_W-1:0] shadow_pattern;
	logic [LEN_W-1:0] shadow_length;
	int               shadow_state;
	logic [IDX_W-1:0] shadow_index;
	bit               shadow_reported;

	// Reports the shadow has predicted but the block has not yet delivered, oldest first.
	out_item_t pending_reports[$];

	int  fail_count = 0;
	int  live_items = 0;
	int  quiet_cycles = 0;
	int  hold_cycles = 0;
	bit  tx_idle = 1'b0;
	bit  rx_idle = 1'b0;

	automaton_pattern_search i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text         (text),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow automaton
	// ------------------------------------------------------------------

	function automatic logic [BYTE_W-1:0] pattern_char(int k);
		return shadow_pattern[8*(k % 8) +: 8];
	endfunction

	// Pattern length in force: zero behaves as one, anything above the maximum is clamped.
	function automatic int active_length();
		if (shadow_length == 0)
			return 1;
		if (shadow_length > MAX_PATTERN)
			return MAX_PATTERN;
		return int'(shadow_length);
	endfunction

	// Length of the longest pattern prefix that is a suffix of the text once x is appended.
	function automatic int longest_prefix_suffix(int s, int m, logic [BYTE_W-1:0] x);
		int len;
		int i;
		bit agree;
		if (s > m)
			s = m;
		if (s < m && x == pattern_char(s))
			return s + 1;
		for (len = s; len > 0; len--) begin
			if (pattern_char(len - 1) != x)
				continue;
			agree = 1'b1;
			for (i = 0; i + 1 < len; i++)
				if (pattern_char(i) != pattern_char(s - len + 1 + i))
					agree = 1'b0;
			if (agree)
				return len;
		end
		return 0;
	endfunction

	function automatic void clear_stream();
		shadow_state    = 0;
		shadow_index    = '0;
		shadow_reported = 1'b0;
	endfunction

	// Advance the shadow by one accepted text request and queue any report it causes.
	function automatic void predict_search(in_item_t req);
		int        m;
		out_item_t rep;
		m = active_length();
		live_items++;
		if (!shadow_reported) begin
			shadow_state = longest_prefix_suffix(shadow_state, m, req.text_byte) % 16;
			if (shadow_state == m) begin
				shadow_reported = 1'b1;
				rep.found       = 1'b1;
				rep.match_start = shadow_index + 16'd1 - IDX_W'(m);
				pending_reports.push_back(rep);
			end else if (req.last_of_text) begin
				rep.found       = 1'b0;
				rep.match_start = '0;
				pending_reports.push_back(rep);
			end
		end
		if (req.last_of_text)
			clear_stream();
		else if (shadow_index < INDEX_CEILING)
			shadow_index++;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Send one text request: idle for a drawn gap, then hold valid until it is taken.
	// Valid is left high on return so that a back-to-back request needs no toggle.
	task automatic send_text(logic [BYTE_W-1:0] b, bit last);
		in_item_t req;
		int       gap;
		req.text_byte    = b;
		req.last_of_text = last;
		gap = tx_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_valid <= 1'b1;
		text       <= req;
		do @(posedge clk); while (!text_ready);
		predict_search(req);
	endtask

	// Pause the sender until every predicted report has come back, then let the
	// pipeline settle so that a byte with no report has surely left it.
	task automatic drain_pipeline();
		text_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write a register with the block idle; mirror the write and the stream clear.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		drain_pipeline();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PATTERN_BYTES)
			shadow_pattern = value;
		else
			shadow_length = value[LEN_W-1:0];
		clear_stream();
	endtask

	// One random text: mostly characters of the pattern, often with a whole
	// occurrence planted in it, now and then pure noise.
	task automatic send_random_text(int max_len);
		int len;
		int m;
		int pos;
		int j;
		bit plant;
		bit noise;
		logic [BYTE_W-1:0] b;
		m     = active_length();
		len   = $urandom_range(1, max_len);
		plant = ($urandom_range(0, 1) == 1) && (len >= m);
		pos   = plant ? $urandom_range(0, len - m) : 0;
		noise = ($urandom_range(0, 7) == 0);
		for (j = 0; j < len; j++) begin
			if (plant && j >= pos && j < pos + m)
				b = pattern_char(j - pos);
			else if (noise || $urandom_range(0, 9) >= 7)
				b = BYTE_W'($urandom_range(0, 255));
			else
				b = pattern_char($urandom_range(0, m - 1));
			send_text(b, j == len - 1);
		end
	endtask

	// Random pattern: fully random bytes, or drawn from a tiny alphabet so that
	// self-overlapping patterns exercise the fallback of the automaton.
	function automatic logic [CFG_W-1:0] random_pattern(int letters);
		logic [CFG_W-1:0] p;
		int k;
		p = {$urandom, $urandom};
		if (letters > 0)
			for (k = 0; k < 8; k++)
				p[8*k +: 8] = 8'h61 + BYTE_W'($urandom_range(0, letters - 1));
		return p;
	endfunction

	// ------------------------------------------------------------------
	// Receiver: random stalls per report, plus a long hold-off on request
	// ------------------------------------------------------------------

	initial begin : receiver
		int stall_left;
		stall_left = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				result_ready <= 1'b0;
				hold_cycles--;
			end else if (result_valid && result_ready) begin
				stall_left = rx_idle ? $urandom_range(0, 14) : 0;
				result_ready <= (stall_left == 0);
			end else if (stall_left > 0) begin
				stall_left--;
				result_ready <= (stall_left == 0);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Scoreboard: every report against the oldest prediction
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_reports.size() == 0) begin
				$error("report with none expected: found=%0d match_start=%0d",
					result.found, result.match_start);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				if (result.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, result.found);
					fail_count++;
				end
				if (result.match_start !== want.match_start) begin
					$error("match_start: expected %0d, got %0d",
						want.match_start, result.match_start);
					fail_count++;
				end
			end
		end
	end

	// Hang detection: count cycles in which no request moves on any port.
	always @(posedge clk) begin
		if ((text_valid && text_ready) || (result_valid && result_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: an all-zero single-character pattern.
	task automatic test_reset_defaults();
		send_text(8'h00, 1'b0); // match at the very first byte
		send_text(8'h5A, 1'b0); // ignored after the report
		send_text(8'hFF, 1'b1); // ignored, but ends the text
		send_text(8'hFF, 1'b1); // one-byte text without a match
		send_text(8'h00, 1'b1); // match on the last byte: single report only
	endtask

	// All-ones eight-byte pattern with an over-range length, then length zero.
	task automatic test_length_extremes();
		int j;
		write_reg(REG_PATTERN_BYTES, {CFG_W{1'b1}});
		write_reg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF); // length 15 clamps to 8
		for (j = 0; j < 8; j++)
			send_text(8'hFF, j == 7);
		write_reg(REG_PATTERN_BYTES, 64'h0123_4567_89AB_CDEF);
		write_reg(REG_PATTERN_LENGTH, 64'h0);                   // length 0 acts as 1
		send_text(8'hEF, 1'b1);
		send_text(8'h01, 1'b1);
	endtask

	// Self-overlapping pattern: the automaton must fall back, not restart.
	task automatic test_overlap_fallback();
		write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0062_6161); // "aab"
		write_reg(REG_PATTERN_LENGTH, 64'd3);
		send_text(8'h61, 1'b0);
		send_text(8'h61, 1'b0);
		send_text(8'h61, 1'b0);
		send_text(8'h62, 1'b1);
	endtask

	// A register write in the middle of a text throws the partial match away.
	task automatic test_restart_on_write();
		write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0000_6261); // "ab"
		write_reg(REG_PATTERN_LENGTH, 64'd2);
		send_text(8'h61, 1'b0);
		write_reg(REG_PATTERN_LENGTH, 64'd2);
		send_text(8'h62, 1'b1);
	endtask

	// Hold the result side off while one-byte texts keep coming, so the output
	// stage fills and the block has to stall its input.
	task automatic test_output_backpressure();
		int j;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0000_0041);
		write_reg(REG_PATTERN_LENGTH, 64'd1);
		drain_pipeline();
		hold_cycles = HOLD_OFF_CYCLES;
		for (j = 0; j < 30; j++)
			send_text((j % 3 == 0) ? 8'h41 : BYTE_W'($urandom_range(0, 255)), 1'b1);
		drain_pipeline();
	endtask

	// Random phases, each with its own pattern, length and idling mix.
	task automatic test_random_texts();
		int p;
		int phase_start;
		logic [CFG_W-1:0] len_word;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			write_reg(REG_PATTERN_BYTES, random_pattern(p % 3 == 0 ? 0 : 1 + p % 3));
			len_word = {$urandom, $urandom};
			len_word[LEN_W-1:0] = (p < MAX_PATTERN) ? LEN_W'(p + 1)
				: LEN_W'($urandom_range(0, 15));
			write_reg(REG_PATTERN_LENGTH, len_word);
			tx_idle = p[0];
			rx_idle = p[1];
			phase_start = live_items;
			while (live_items - phase_start < ITEMS_PER_PHASE)
				send_random_text((p % 4 == 3) ? 60 : 24);
		end
	endtask

	initial begin : main
		arst_n     <= 1'b0;
		text_valid <= 1'b0;
		text       <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_PATTERN_BYTES;
		cfg_data   <= '0;
		shadow_pattern = '0;
		shadow_length  = LEN_W'(1);
		clear_stream();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_length_extremes();
		test_overlap_fallback();
		test_restart_on_write();
		test_output_backpressure();
		test_random_texts();

		drain_pipeline();
		if (pending_reports.size() != 0) begin
			$error("%0d expected reports never arrived", pending_reports.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
hdl/aps_pkg.sv
hdl/aps_cell.sv
hdl/aps_out_buf.sv
hdl/automaton_pattern_search.sv
verif/tb.sv
